// ----- src/midi_byte_stream_decoder_core_assert.svh -----
// Assertion macros shared by the MIDI byte stream decoder RTL.
// Needs nothing else; the files that check their own logic include it.
`ifndef MIDI_BYTE_STREAM_DECODER_CORE_ASSERT_SVH
`define MIDI_BYTE_STREAM_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define MBSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mbsd: same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define MBSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mbsd: next-cycle check failed");

`endif

// ----- src/mbsd_pkg.sv -----
// Types, status codes and lookup functions for the MIDI byte stream decoder.
// Has no dependencies; used by mbsd_decode and the top level.
`default_nettype none

package mbsd_pkg;

    // Status byte fields and masks.
    localparam logic [7:0] STATUS_MASK = 8'h80;
    localparam logic [7:0] SYS_BASE    = 8'hF0;
    localparam logic [7:0] LOW_NIBBLE  = 8'h0F;
    localparam logic [7:0] BYTE_MASK   = 8'hFF;

    // Message types with a known data length.
    localparam logic [7:0] ST_NOTE_OFF   = 8'h80;
    localparam logic [7:0] ST_NOTE_ON    = 8'h90;
    localparam logic [7:0] ST_POLY_PRESS = 8'hA0;
    localparam logic [7:0] ST_CTRL_CHG   = 8'hB0;
    localparam logic [7:0] ST_PROG_CHG   = 8'hC0;
    localparam logic [7:0] ST_CHAN_PRESS = 8'hD0;
    localparam logic [7:0] ST_PITCH_BEND = 8'hE0;
    localparam logic [7:0] ST_TIME_CODE  = 8'hF1;
    localparam logic [7:0] ST_SONG_POS   = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL   = 8'hF3;
    localparam logic [7:0] ST_TUNE_REQ   = 8'hF6;

    // System status bytes without a known data length.
    localparam logic [7:0] ST_SYSEX      = 8'hF0;
    localparam logic [7:0] ST_UNDEF_F4   = 8'hF4;
    localparam logic [7:0] ST_UNDEF_F5   = 8'hF5;
    localparam logic [7:0] ST_SYSEX_END  = 8'hF7;
    localparam logic [7:0] ST_UNDEF_F9   = 8'hF9;
    localparam logic [7:0] ST_UNDEF_FD   = 8'hFD;

    // Real-time status bytes.
    localparam logic [7:0] RT_CLOCK    = 8'hF8;
    localparam logic [7:0] RT_START    = 8'hFA;
    localparam logic [7:0] RT_CONTINUE = 8'hFB;
    localparam logic [7:0] RT_STOP     = 8'hFC;
    localparam logic [7:0] RT_SENSE    = 8'hFE;
    localparam logic [7:0] RT_RESET    = 8'hFF;

    // Codes of the data-left counter.
    localparam logic [1:0] LEFT_NONE    = 2'd0;
    localparam logic [1:0] LEFT_ONE     = 2'd1;
    localparam logic [1:0] LEFT_TWO     = 2'd2;
    localparam logic [1:0] LEFT_UNKNOWN = 2'd3;

    // Held message state.
    typedef struct packed {
        logic [7:0] held_type;
        logic [3:0] held_channel;
        logic [1:0] data_left;
        logic [6:0] held_first_data;
    } t_state;

    // One decoded message and its valid flag.
    typedef struct packed {
        logic        valid;
        logic [7:0]  msg_status;
        logic [3:0]  msg_channel;
        logic [6:0]  first_data;
        logic [6:0]  second_data;
        logic [13:0] combined_value;
        logic [1:0]  data_count;
    } t_result;

    // Number of data bytes that follow a held type.
    function automatic logic [1:0] length_of(input logic [7:0] t);
        logic [1:0] len;
        case (t) inside
            ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRESS, ST_CTRL_CHG,
            ST_PITCH_BEND, ST_SONG_POS: len = LEFT_TWO;
            ST_PROG_CHG, ST_CHAN_PRESS, ST_TIME_CODE, ST_SONG_SEL: len = LEFT_ONE;
            ST_TUNE_REQ: len = LEFT_NONE;
            default: len = LEFT_UNKNOWN;
        endcase
        return len;
    endfunction

    // True for the real-time status bytes.
    function automatic logic is_realtime(input logic [7:0] b);
        logic rt;
        case (b) inside
            RT_CLOCK, RT_START, RT_CONTINUE, RT_STOP, RT_SENSE, RT_RESET: rt = 1'b1;
            default: rt = 1'b0;
        endcase
        return rt;
    endfunction

endpackage

`default_nettype wire

// ----- src/mbsd_decode.sv -----
// Combinational decode of one MIDI byte against the held message state.
// Depends on mbsd_pkg for the state and result types and the length table.
`default_nettype none

module mbsd_decode (
    input  wire logic [7:0]       i_byte,
    input  wire mbsd_pkg::t_state i_state,
    output mbsd_pkg::t_state      o_state,
    output mbsd_pkg::t_result     o_result
);
    import mbsd_pkg::*;

    logic [7:0] status_type;
    logic [3:0] status_chan;
    logic [1:0] status_len;
    logic [1:0] eff_left;
    logic [1:0] held_len;
    t_result    res;

    // Type and channel that a non-real-time status byte would hold.
    always_comb begin
        if (i_byte >= SYS_BASE) begin
            status_type = i_byte;
            status_chan = '0;
        end else begin
            status_type = i_byte & SYS_BASE;
            status_chan = i_byte[3:0] & LOW_NIBBLE[3:0];
        end
        status_len = length_of(status_type);
        held_len   = length_of(i_state.held_type);
        // Running status: with nothing pending, the held type starts over.
        eff_left   = (i_state.data_left == LEFT_NONE) ? held_len : i_state.data_left;
    end

    // Next state and the message, if one completes.
    always_comb begin
        o_state = i_state;
        res     = '0;
        if ((i_byte & STATUS_MASK) != 8'h00) begin
            if (is_realtime(i_byte)) begin
                res.valid      = 1'b1;
                res.msg_status = i_byte;
            end else begin
                o_state.held_type    = status_type;
                o_state.held_channel = status_chan;
                o_state.data_left    = status_len;
                if (status_len == LEFT_NONE) begin
                    res.valid       = 1'b1;
                    res.msg_status  = status_type;
                    res.msg_channel = status_chan;
                end
            end
        end else begin
            o_state.data_left = eff_left;
            case (eff_left)
                LEFT_TWO: begin
                    o_state.held_first_data = i_byte[6:0];
                    o_state.data_left       = LEFT_ONE;
                end
                LEFT_ONE: begin
                    o_state.data_left = LEFT_NONE;
                    res.valid         = 1'b1;
                    res.msg_status    = i_state.held_type;
                    res.msg_channel   = i_state.held_channel;
                    if (held_len == LEFT_TWO) begin
                        res.first_data  = i_state.held_first_data;
                        res.second_data = i_byte[6:0];
                        res.data_count  = LEFT_TWO;
                    end else begin
                        res.first_data = i_byte[6:0];
                        res.data_count = LEFT_ONE;
                    end
                end
                default: begin
                    // Tune request or unknown type: the byte is dropped.
                end
            endcase
        end
        // Pitch bend and song position also carry the 14-bit value.
        if (res.msg_status == ST_PITCH_BEND || res.msg_status == ST_SONG_POS) begin
            res.combined_value = {res.second_data, res.first_data};
        end
        o_result = res;
    end

endmodule

`default_nettype wire

// ----- src/midi_byte_stream_decoder_core.sv -----
// Top level of the MIDI byte stream decoder: input register, decode, result register.
// Depends on mbsd_pkg, mbsd_decode and midi_byte_stream_decoder_core_assert.svh.
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+-----------------------------------------------
//  in      | i_in_valid / o_in_stall | i_in_byte
//  out     | o_out_valid/i_out_stall | o_msg_status, o_msg_channel, o_first_data,
//          |                         | o_second_data, o_combined_value, o_data_count
//
// A byte's message is written into the result register from the decode of the input register, and
// one byte is taken every cycle while the input does not stall.
// A byte that completes no message leaves the pipe without touching the output.
// Synchronous reset clears the held message and both valid flags.
// The input stalls only while a message waits in the input stage and the result
// register is held by an output stall.
`default_nettype none

`include "midi_byte_stream_decoder_core_assert.svh"

module midi_byte_stream_decoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_msg_status,
    output logic [3:0]       o_msg_channel,
    output logic [6:0]       o_first_data,
    output logic [6:0]       o_second_data,
    output logic [13:0]      o_combined_value,
    output logic [1:0]       o_data_count
);
    import mbsd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_state     r_state;
    t_state     n_state;
    t_result    dec_result;
    logic       r_out_valid;
    t_result    r_out;
    logic       out_free;
    logic       s1_go;
    logic       in_free;

    // Decode of the byte in the input register.
    mbsd_decode u_decode (
        .i_byte   (r_in_byte),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (dec_result)
    );

    // Flow control: the input stage moves on when its message has room or it has none.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_go      = r_in_valid && (out_free || !dec_result.valid);
    assign in_free    = !r_in_valid || s1_go;
    assign o_in_stall = !in_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in_valid;
        end
        if (in_free && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    // Held message state advances as each byte leaves the input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (s1_go) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_go && dec_result.valid;
        end
        if (out_free && s1_go && dec_result.valid) begin
            r_out <= dec_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_msg_status     = r_out.msg_status;
    assign o_msg_channel    = r_out.msg_channel;
    assign o_first_data     = r_out.first_data;
    assign o_second_data    = r_out.second_data;
    assign o_combined_value = r_out.combined_value;
    assign o_data_count     = r_out.data_count;

    // A blocked byte stays in the input stage unchanged.
    `MBSD_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !s1_go,
        r_in_valid && $stable(r_in_byte))
    // The 14-bit value is only carried by pitch bend and song position.
    `MBSD_ASSERT_NOW(a_comb_type, i_clk, i_rst_n, r_out_valid && (r_out.combined_value != '0),
        r_out.msg_status == ST_PITCH_BEND || r_out.msg_status == ST_SONG_POS)
    // A message without data carries zero data fields.
    `MBSD_ASSERT_NOW(a_no_data, i_clk, i_rst_n, r_out_valid && (r_out.data_count == LEFT_NONE),
        r_out.first_data == '0 && r_out.second_data == '0)
    // A message is never dropped: a new one is written only when the old one left.
    `MBSD_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, s1_go && dec_result.valid, out_free)

endmodule

`default_nettype wire
